// ===== rtl/core/npc_pkg.sv =====
// Shared types and constants of the nearest prototype classifier.
`default_nettype none

package npc_pkg;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } npc_state_t;

  // Item kinds carried in the input tuser.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_PROTOS    = 2'd0;
  localparam logic [1:0] REG_DIMS      = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  // Register widths and reset values.
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned THR_W   = 63;
  localparam logic [COUNT_W-1:0] PROTOS_RESET = 5'd8;
  localparam logic [COUNT_W-1:0] DIMS_RESET   = 5'd8;

  // Distance arithmetic: squares and sums saturate at all ones of DIST_W bits.
  localparam int unsigned DIST_W = 54;
  localparam int unsigned MAG_W  = 27;
  localparam int unsigned DIFF_W = 34;
  localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};
  localparam logic [DIFF_W-1:0] ROOT_LIMIT = 34'd134217727;

  // Field widths of the output beat.
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned OUT_DATA_W = 64;

endpackage

`default_nettype wire

// ===== rtl/core/npc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module npc_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/nearest_prototype_classifier_core.sv =====
// Top level of the nearest prototype classifier: one shared distance pipeline.
//
//  Channel   Direction  Beat contents
//  s_axis    in         tuser: opcode; tdata: proto_index, coef_index, coef_value
//  m_axis    out        tuser: known; tdata: match_index, best_dist_sq
//  cfg       in         cfg_index selects the register, cfg_data holds the value
//
// A load beat writes the prototype RAM directly and leaves the sequencer idle.
// A query beat holds off the next beat while the sequencer issues N prototypes,
// where N is prototypes_in_use clamped to 1..MAX_PROTOTYPES, then drains the
// pipeline and, on the last coefficient, passes through the emit state; the
// single subtract, square and accumulate pipeline visits one prototype per cycle.
// Reset clears the control state and the accumulator valid bits; no RAM sweep.
// A finished result sits in the output register; the next result waits in the
// emit state while that register is still held by the downstream side.
`default_nettype none

module nearest_prototype_classifier_core
  import npc_pkg::*;
#(
  parameter int unsigned MAX_PROTOTYPES = 16,
  parameter int unsigned MAX_DIMS       = 16,
  parameter int unsigned COEF_BITS      = 24,
  parameter int unsigned IN_DATA_W      = ((2 * IDX_W + COEF_BITS + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata: proto_index [3:0], coef_index [7:4], coef_value [8 +: COEF_BITS], zero fill
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: opcode
  input  wire logic                  s_axis_tuser,
  // Result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // tdata: match_index [3:0], best_dist_sq [57:4], zero fill
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // tuser: known
  output logic                       m_axis_tuser,
  // Configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [63:0]           cfg_data
);

  localparam int unsigned PW  = (MAX_PROTOTYPES > 1) ? $clog2(MAX_PROTOTYPES) : 1;
  localparam int unsigned DWI = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned STORE_DEPTH = MAX_PROTOTYPES * MAX_DIMS;
  localparam int unsigned SAW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // Configuration registers.
  logic [COUNT_W-1:0] prototypes_in_use;
  logic [COUNT_W-1:0] dims_in_use;
  logic [THR_W-1:0]   threshold_sq;

  // Sequencer and query context.
  npc_state_t state, state_next;
  logic [PW-1:0]        cnt;
  logic [PW-1:0]        nprot_last;
  logic [DWI-1:0]       ndims_last;
  logic signed [COEF_BITS-1:0] q_value;
  logic [IDX_W-1:0]     q_cidx;
  logic                 q_last;

  // Accumulator valid bits; an entry that is not valid reads as zero.
  logic [MAX_PROTOTYPES-1:0] acc_valid;

  // Pipeline stages of the distance unit.
  logic              s1_valid, s2_valid, s3_valid;
  logic [PW-1:0]     s1_idx, s2_idx, s3_idx;
  logic              s1_accv;
  logic [MAG_W-1:0]  s2_mag;
  logic              s2_over;
  logic [DIST_W-1:0] s2_acc, s3_acc, s3_sq;

  // Running minimum.
  logic [DIST_W-1:0] best_dist;
  logic [PW-1:0]     best_idx;

  // Input beat fields.
  logic                        in_accept;
  logic [IDX_W-1:0]            in_pidx;
  logic [IDX_W-1:0]            in_cidx;
  logic [COEF_BITS-1:0]        in_value;
  logic                        load_ok;
  logic                        query_ok;
  logic                        query_start;

  // Control decoded from the state.
  logic issue;
  logic emit_load;

  // RAM connections.
  logic [SAW-1:0]       store_wr_addr;
  logic [SAW-1:0]       store_rd_addr;
  logic [COEF_BITS-1:0] store_rd_data;
  logic [DIST_W-1:0]    acc_rd_data;

  // Distance datapath.
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        diff_abs;
  logic [DIST_W-1:0]        prod;
  logic [DIST_W:0]          sum;
  logic [DIST_W-1:0]        sum_sat;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign in_pidx   = s_axis_tdata[IDX_W-1:0];
  assign in_cidx   = s_axis_tdata[2*IDX_W-1:IDX_W];
  assign in_value  = s_axis_tdata[2*IDX_W +: COEF_BITS];
  assign cfg_ready = 1'b1;

  // Clamp the counts: zero acts as one, above the maximum acts as the maximum.
  always_comb begin
    if (prototypes_in_use == '0) begin
      nprot_last = '0;
    end else if (32'(prototypes_in_use) > MAX_PROTOTYPES) begin
      nprot_last = PW'(MAX_PROTOTYPES - 1);
    end else begin
      nprot_last = PW'(prototypes_in_use - 5'd1);
    end
    if (dims_in_use == '0) begin
      ndims_last = '0;
    end else if (32'(dims_in_use) > MAX_DIMS) begin
      ndims_last = DWI'(MAX_DIMS - 1);
    end else begin
      ndims_last = DWI'(dims_in_use - 5'd1);
    end
  end

  // Decode an accepted input beat.
  assign load_ok  = (32'(in_pidx) < MAX_PROTOTYPES) && (32'(in_cidx) < MAX_DIMS);
  assign query_ok = 9'(in_cidx) <= 9'(ndims_last);
  assign query_start = in_accept && (s_axis_tuser == OP_QUERY) && query_ok;

  assign store_wr_addr = SAW'(32'(in_pidx) * MAX_DIMS + 32'(in_cidx));
  assign store_rd_addr = SAW'(32'(cnt) * MAX_DIMS + 32'(q_cidx));

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      prototypes_in_use <= PROTOS_RESET;
      dims_in_use       <= DIMS_RESET;
      threshold_sq      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PROTOS:    prototypes_in_use <= cfg_data[COUNT_W-1:0];
        REG_DIMS:      dims_in_use       <= cfg_data[COUNT_W-1:0];
        REG_THRESHOLD: threshold_sq      <= cfg_data[THR_W-1:0];
        default:       ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (query_start) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (cnt == nprot_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!(s1_valid || s2_valid || s3_valid)) begin
          state_next = q_last ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    emit_load     = 1'b0;
    unique case (state)
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_RUN:   issue = 1'b1;
      ST_DRAIN: ;
      ST_EMIT:  emit_load = !m_axis_tvalid || m_axis_tready;
      default:  ;
    endcase
  end

  // Sequencer registers and query context.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (query_start) begin
        cnt <= '0;
      end else if (issue) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (query_start) begin
      q_value <= $signed(in_value);
      q_cidx  <= in_cidx;
      q_last  <= 9'(in_cidx) == 9'(ndims_last);
    end
  end

  // Accumulator valid bits: the first coefficient of a query clears them all.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= '0;
    end else if (query_start && (in_cidx == '0)) begin
      acc_valid <= '0;
    end else if (s3_valid) begin
      acc_valid[s3_idx] <= 1'b1;
    end
  end

  // Prototype coefficient store.
  npc_ram #(
    .WIDTH (COEF_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_accept && (s_axis_tuser == OP_LOAD) && load_ok),
    .wr_addr (store_wr_addr),
    .wr_data (in_value),
    .rd_en   (issue),
    .rd_addr (store_rd_addr),
    .rd_data (store_rd_data)
  );

  // Distance accumulators.
  npc_ram #(
    .WIDTH (DIST_W),
    .DEPTH (MAX_PROTOTYPES)
  ) u_acc (
    .clk     (clk),
    .wr_en   (s3_valid),
    .wr_addr (s3_idx),
    .wr_data (sum_sat),
    .rd_en   (issue),
    .rd_addr (cnt),
    .rd_data (acc_rd_data)
  );

  // Stage valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // Stage one: difference and magnitude, with the square overflow test.
  assign diff     = DIFF_W'(q_value) - DIFF_W'($signed(store_rd_data));
  assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  // Stage two: saturating square.
  assign prod = s2_mag * s2_mag;

  // Stage three: saturating accumulate.
  assign sum     = {1'b0, s3_acc} + {1'b0, s3_sq};
  assign sum_sat = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];

  always_ff @(posedge clk) begin
    s1_idx  <= cnt;
    s1_accv <= acc_valid[cnt];
    s2_idx  <= s1_idx;
    s2_mag  <= diff_abs[MAG_W-1:0];
    s2_over <= diff_abs > ROOT_LIMIT;
    s2_acc  <= s1_accv ? acc_rd_data : '0;
    s3_idx  <= s2_idx;
    s3_sq   <= s2_over ? DIST_MAX : prod;
    s3_acc  <= s2_acc;
  end

  // Running minimum; prototypes arrive in rising order, so ties keep the lower index.
  always_ff @(posedge clk) begin
    if (s3_valid && ((s3_idx == '0) || (sum_sat < best_dist))) begin
      best_dist <= sum_sat;
      best_idx  <= s3_idx;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      m_axis_tdata <= {{(OUT_DATA_W - IDX_W - DIST_W){1'b0}}, best_dist, IDX_W'(best_idx)};
      m_axis_tuser <= THR_W'(best_dist) < threshold_sq;
    end
  end

  // No input beat is taken while a prototype is still in the distance pipeline.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !(s1_valid || s2_valid || s3_valid))
    else $error("input accepted while the distance pipeline is busy");

  // A new result appears only out of the emit state.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_EMIT))
    else $error("result raised outside the emit state");

  // Accumulator writes stay within the prototypes in use.
  assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> (s3_idx <= nprot_last))
    else $error("accumulator write beyond the prototypes in use");

endmodule

`default_nettype wire
